### rtl/assert_macros.svh
// Assertion helpers for the RTL that carries checks (the sequencer top).
// HSS_ASSERT expects clk and rst_n in the calling scope, HSS_ASSERT_ALWAYS only clk.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// Checked only while out of reset.
`define HSS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked at every edge, reset included.
`define HSS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define HSS_ASSERT(lbl, prop, msg)
`define HSS_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

### rtl/hss_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package hss_pkg;

  localparam int unsigned TICKS_PER_MINUTE = 60000000;

  localparam int REV_W      = 16;
  localparam int SPEED_W    = 8;
  localparam int SPD_W      = 5;            // clamped speed, 1..16
  localparam int DIVISOR_W  = REV_W + SPD_W;
  localparam int ELAPSED_W  = 26;
  localparam int STEPS_W    = 16;
  localparam int PHASE_W    = 3;
  localparam int COIL_W     = 4;
  localparam int OP_W       = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;
  localparam int DIV_CNT_W  = 5;

  localparam logic [ELAPSED_W-1:0] ELAPSED_MAX    = '1;
  localparam logic [ELAPSED_W-1:0] DIVIDEND       = ELAPSED_W'(TICKS_PER_MINUTE);
  localparam logic [ELAPSED_W-1:0] INTERVAL_RESET =
    ELAPSED_W'(TICKS_PER_MINUTE / 4096 / 16);
  localparam logic [DIV_CNT_W-1:0] DIV_LAST       = DIV_CNT_W'(ELAPSED_W - 1);

  localparam logic [REV_W-1:0]   REV_RESET   = 16'd4096;
  localparam logic [SPEED_W-1:0] SPEED_RESET = 8'd16;
  localparam logic [SPEED_W-1:0] SPEED_LIMIT = 8'd16;

  // Input op codes
  localparam logic [OP_W-1:0] OP_TICK = 2'd0;
  localparam logic [OP_W-1:0] OP_MOVE = 2'd1;
  localparam logic [OP_W-1:0] OP_STOP = 2'd2;

  // Config register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_STEPS_PER_REV = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED_RPM     = 1'd1;

  // Half-step coil pattern per phase
  function automatic logic [COIL_W-1:0] coil_pattern(input logic [PHASE_W-1:0] ph);
    logic [COIL_W-1:0] pat;
    unique case (ph)
      3'd0: pat = 4'h1;
      3'd1: pat = 4'h3;
      3'd2: pat = 4'h2;
      3'd3: pat = 4'h6;
      3'd4: pat = 4'h4;
      3'd5: pat = 4'hC;
      3'd6: pat = 4'h8;
      default: pat = 4'h9;
    endcase
    return pat;
  endfunction

  typedef struct packed {
    logic                 busy;
    logic [ELAPSED_W-1:0] interval;
  } hss_div_stat_t;

endpackage

`default_nettype wire

### rtl/hss_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface hss_in_if import hss_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [OP_W-1:0]           op;
  logic signed [STEPS_W-1:0] steps;

  modport source (output valid, output op, output steps, input ready);
  modport sink   (input valid, input op, input steps, output ready);
endinterface

interface hss_out_if import hss_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [COIL_W-1:0]  coils;
  logic               stepped;
  logic               busy_res;
  logic [STEPS_W-1:0] steps_remaining;

  modport source (output valid, output coils, output stepped, output busy_res,
                  output steps_remaining, input ready);
  modport sink   (input valid, input coils, input stepped, input busy_res,
                  input steps_remaining, output ready);
endinterface

`default_nettype wire

### rtl/half_step_stepper_sequencer.sv
`timescale 1ns / 1ps
`default_nettype none

// Half-step sequencer for a four-coil unipolar stepper. Each input item is
// one op: a one-microsecond tick, a signed move (sign sets direction, the
// magnitude is loaded as steps left) or a stop (coils off, steps dropped).
// Every item gives exactly one result: coil drive, a stepped flag, busy and
// steps remaining. Items are taken at one per cycle unless the divider
// runs or the result side stalls; the step logic sits between the accepted
// item and a single result register, so a new item is taken in the same
// cycle that the previous result transfers out. The step interval is
// 60000000 / steps_per_rev / min(speed_rpm, 16), zero settings counted as
// one. After each config write a bit-serial divider rebuilds it, with
// in_chan.ready low from start_r on, one quotient bit per cycle of the
// 26-bit interval. Reset loads the 915 reset interval, so no wait follows.
// Elapsed time starts saturated, so the first move steps on its first tick.
`include "assert_macros.svh"

module half_step_stepper_sequencer import hss_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  hss_in_if.sink                     in_chan,
  hss_out_if.source                  out_chan
);

  logic [REV_W-1:0]     rev_r;
  logic [SPEED_W-1:0]   speed_r;
  logic                 start_r;     // kicks the divider the cycle after a write

  logic [REV_W-1:0]     rev_eff;
  logic [SPD_W-1:0]     spd_eff;
  logic [DIVISOR_W-1:0] divisor;
  logic                 div_busy;
  hss_div_stat_t        div_stat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rev_r   <= REV_RESET;
      speed_r <= SPEED_RESET;
      start_r <= 1'b0;
    end else begin
      start_r <= cfg_we;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_STEPS_PER_REV: rev_r   <= cfg_wdata[REV_W-1:0];
          CFG_SPEED_RPM:     speed_r <= cfg_wdata[SPEED_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Zero counts as one; speed clamps at the limit.
  always_comb begin
    rev_eff = (rev_r == '0) ? REV_W'(1) : rev_r;
    if (speed_r == '0)              spd_eff = SPD_W'(1);
    else if (speed_r > SPEED_LIMIT) spd_eff = SPD_W'(SPEED_LIMIT);
    else                            spd_eff = SPD_W'(speed_r);
    divisor = DIVISOR_W'(rev_eff) * DIVISOR_W'(spd_eff);  // 16 x 5 bits
  end

  hss_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start_r),
    .divisor (divisor),
    .stat    (div_stat)
  );

  // Hold off items until the interval is valid again.
  assign div_busy = div_stat.busy || start_r;

  hss_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .enable   (!div_busy),
    .interval (div_stat.interval),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  `HSS_ASSERT_ALWAYS(a_reset_div_idle, !rst_n |=> !div_busy, "divider not idle after reset")
  `HSS_ASSERT(a_cfg_starts_div, cfg_we |=> div_busy, "config write did not start divider")
  `HSS_ASSERT(a_no_take_while_div, div_busy |-> !in_chan.ready, "item taken during divide")
  `HSS_ASSERT(a_interval_nonzero, $fell(div_stat.busy) |-> div_stat.interval != '0,
              "zero step interval")
  `HSS_ASSERT(a_step_drives_coil, out_chan.valid && out_chan.stepped |-> out_chan.coils != '0,
              "step result with coils off")

endmodule

`default_nettype wire

### rtl/hss_div.sv
`timescale 1ns / 1ps
`default_nettype none

// Restoring divider: TICKS_PER_MINUTE / divisor, one quotient bit per cycle.
module hss_div import hss_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  input  wire logic [DIVISOR_W-1:0] divisor,
  output hss_div_stat_t             stat
);

  logic                 busy_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [DIVISOR_W-1:0] rem_r;
  logic [DIVISOR_W-1:0] div_r;
  logic [ELAPSED_W-1:0] num_r;      // dividend bits out, quotient bits in
  logic [ELAPSED_W-1:0] interval_r;

  logic [DIVISOR_W:0]   shifted;
  logic                 ge;
  logic [DIVISOR_W-1:0] rem_nxt;
  logic [ELAPSED_W-1:0] num_nxt;

  always_comb begin
    shifted = {rem_r, num_r[ELAPSED_W-1]};
    ge      = (shifted >= {1'b0, div_r});
    rem_nxt = ge ? DIVISOR_W'(shifted - {1'b0, div_r}) : shifted[DIVISOR_W-1:0];
    num_nxt = {num_r[ELAPSED_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r     <= 1'b0;
      cnt_r      <= '0;
      interval_r <= INTERVAL_RESET;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == DIV_LAST) begin
        busy_r     <= 1'b0;
        interval_r <= num_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      div_r <= divisor;
      num_r <= DIVIDEND;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      num_r <= num_nxt;
    end
  end

  assign stat.busy     = busy_r;
  assign stat.interval = interval_r;

endmodule

`default_nettype wire

### rtl/hss_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Per-item step logic and result register.
module hss_core import hss_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 enable,
  input  wire logic [ELAPSED_W-1:0] interval,
  hss_in_if.sink                    in_chan,
  hss_out_if.source                 out_chan
);

  logic [PHASE_W-1:0]   phase_r,   phase_nxt;
  logic                 dir_r,     dir_nxt;
  logic [STEPS_W-1:0]   left_r,    left_nxt;
  logic [ELAPSED_W-1:0] elapsed_r, elapsed_nxt;
  logic [COIL_W-1:0]    coil_r,    coil_nxt;

  logic                 out_valid_r;
  logic                 stepped_r;
  logic                 busy_r;
  logic [STEPS_W-1:0]   remain_r;
  logic [COIL_W-1:0]    coils_out_r;

  logic                 accept;
  logic [ELAPSED_W-1:0] e_inc;
  logic [STEPS_W-1:0]   raw;
  logic [STEPS_W-1:0]   mag_neg;
  logic                 do_step;

  assign in_chan.ready = enable && (!out_valid_r || out_chan.ready);
  assign accept        = in_chan.valid && in_chan.ready;

  always_comb begin
    raw         = STEPS_W'(unsigned'(in_chan.steps));
    mag_neg     = STEPS_W'(~raw + 1'b1);
    e_inc       = (elapsed_r == ELAPSED_MAX) ? elapsed_r : ELAPSED_W'(elapsed_r + 1'b1);
    do_step     = 1'b0;
    phase_nxt   = phase_r;
    dir_nxt     = dir_r;
    left_nxt    = left_r;
    elapsed_nxt = elapsed_r;
    coil_nxt    = coil_r;
    unique case (in_chan.op)
      OP_TICK: begin
        elapsed_nxt = e_inc;
        if ((left_r != '0) && (e_inc >= interval)) begin
          do_step     = 1'b1;
          phase_nxt   = dir_r ? PHASE_W'(phase_r + 1'b1) : PHASE_W'(phase_r - 1'b1);
          coil_nxt    = coil_pattern(phase_nxt);
          left_nxt    = STEPS_W'(left_r - 1'b1);
          elapsed_nxt = '0;
        end
      end
      OP_MOVE: begin
        if (raw[STEPS_W-1]) begin
          dir_nxt  = 1'b0;
          left_nxt = mag_neg;
        end else begin
          if (raw != '0) dir_nxt = 1'b1;
          left_nxt = raw;
        end
      end
      OP_STOP: begin
        coil_nxt = '0;
        left_nxt = '0;
      end
      default: ;  // unused code: state unchanged
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= '0;
      dir_r       <= 1'b0;
      left_r      <= '0;
      elapsed_r   <= ELAPSED_MAX;
      coil_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        phase_r   <= phase_nxt;
        dir_r     <= dir_nxt;
        left_r    <= left_nxt;
        elapsed_r <= elapsed_nxt;
        coil_r    <= coil_nxt;
      end
      if (accept)                out_valid_r <= 1'b1;
      else if (out_chan.ready)   out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      coils_out_r <= coil_nxt;
      stepped_r   <= do_step;
      busy_r      <= (left_nxt != '0);
      remain_r    <= left_nxt;
    end
  end

  assign out_chan.valid           = out_valid_r;
  assign out_chan.coils           = coils_out_r;
  assign out_chan.stepped         = stepped_r;
  assign out_chan.busy_res        = busy_r;
  assign out_chan.steps_remaining = remain_r;

endmodule

`default_nettype wire

### tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import hss_pkg::*;

  // Op code 3 is not defined by the block; it must report state untouched.
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  // Cycles with no transfer on either channel before the run is abandoned.
  // The slowest legal gap is a config rebuild or a random stall on each
  // side, so this is many times over.
  localparam int STALL_LIMIT = 2000;

  // Coil pattern per half-step phase, phase 0 first.
  localparam logic [COIL_W-1:0] HALF_STEP [0:7] =
    '{4'h1, 4'h3, 4'h2, 4'h6, 4'h4, 4'hC, 4'h8, 4'h9};

  typedef struct packed {
    logic [COIL_W-1:0]  coils;
    logic               stepped;
    logic               busy;
    logic [STEPS_W-1:0] remaining;
  } drive_t;

  // Tracks the sequencer state, predicts the drive for every accepted item
  // and checks the results in order.
  class drive_checker;
    logic [REV_W-1:0]     rev_cfg;
    logic [SPEED_W-1:0]   speed_cfg;
    logic [PHASE_W-1:0]   phase;
    logic                 forward;
    logic [STEPS_W-1:0]   left_count;
    logic [ELAPSED_W-1:0] elapsed;
    logic [ELAPSED_W-1:0] interval;
    logic [COIL_W-1:0]    drive;
    drive_t               expected_drive[$];
    int                   errors;

    function new();
      rev_cfg    = REV_RESET;
      speed_cfg  = SPEED_RESET;
      phase      = '0;
      forward    = 1'b0;
      left_count = '0;
      elapsed    = ELAPSED_MAX;
      drive      = '0;
      errors     = 0;
      update_interval();
    endfunction

    // Zero settings count as one; speed is clamped before dividing.
    function void update_interval();
      int unsigned rev;
      int unsigned spd;
      rev = (rev_cfg == 0) ? 1 : rev_cfg;
      spd = (speed_cfg == 0) ? 1 : speed_cfg;
      if (spd > SPEED_LIMIT) spd = SPEED_LIMIT;
      interval = ELAPSED_W'(TICKS_PER_MINUTE / rev / spd);
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_STEPS_PER_REV: rev_cfg = data;
        CFG_SPEED_RPM:     speed_cfg = data[SPEED_W-1:0];
      endcase
      update_interval();
    endfunction

    function int pending();
      return expected_drive.size();
    endfunction

    function void note_item(logic [OP_W-1:0] op, logic [STEPS_W-1:0] raw);
      drive_t want;
      want.stepped = 1'b0;
      case (op)
        OP_TICK: begin
          if (elapsed != ELAPSED_MAX) elapsed++;
          if (left_count != 0 && elapsed >= interval) begin
            phase = forward ? phase + 1'b1 : phase - 1'b1;
            drive = HALF_STEP[phase];
            left_count--;
            elapsed = '0;
            want.stepped = 1'b1;
          end
        end
        OP_MOVE: begin
          // negative: magnitude by two's complement, -32768 gives 32768
          if (raw[STEPS_W-1]) begin
            forward = 1'b0;
            left_count = -raw;
          end else begin
            if (raw != 0) forward = 1'b1;
            left_count = raw;
          end
        end
        OP_STOP: begin
          drive = '0;
          left_count = '0;
        end
        default: ;
      endcase
      want.coils     = drive;
      want.busy      = (left_count != 0);
      want.remaining = left_count;
      expected_drive.push_back(want);
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        errors++;
        $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
      end
    endfunction

    function void check_result(drive_t got);
      drive_t want;
      if (expected_drive.size() == 0) begin
        errors++;
        $display("%0t: unexpected result: expected none, got coils %h stepped %b busy %b rem %0d",
                 $time, got.coils, got.stepped, got.busy, got.remaining);
        return;
      end
      want = expected_drive.pop_front();
      compare_field("coils", want.coils, got.coils);
      compare_field("stepped", want.stepped, got.stepped);
      compare_field("busy_res", want.busy, got.busy);
      compare_field("steps_remaining", want.remaining, got.remaining);
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  // Per-phase switches for stretches without any idling on a side.
  logic quiet_in;
  logic quiet_out;
  int   stall_cycles;

  drive_checker sb = new();

  hss_in_if  in_chan ();
  hss_out_if out_chan ();

  half_step_stepper_sequencer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_chan   (in_chan),
    .out_chan  (out_chan)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Transfers are noted and checked at the rising edge. The input is noted
  // first, so a result is always matched against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_chan.valid && in_chan.ready)
        sb.note_item(in_chan.op, in_chan.steps);
      if (out_chan.valid && out_chan.ready)
        sb.check_result(drive_t'{out_chan.coils, out_chan.stepped,
                                 out_chan.busy_res, out_chan.steps_remaining});
    end
  end

  // Watchdog: any transfer on either side restarts the count.
  always @(posedge clk) begin
    if (!rst_n || (in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles == STALL_LIMIT) begin
        $display("%0t: watchdog expired, no transfer for %0d cycles", $time, STALL_LIMIT);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // Result side: stall a random number of cycles before each transfer,
  // or none at all while quiet_out is set.
  initial begin : result_ready
    int hold;
    out_chan.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      hold = quiet_out ? 0 : $urandom_range(0, 12);
      if (hold != 0) begin
        out_chan.ready <= 1'b0;
        repeat (hold) @(negedge clk);
      end
      out_chan.ready <= 1'b1;
      do @(posedge clk); while (!(out_chan.valid && out_chan.ready));
      @(negedge clk);
    end
  end

  // One input transfer, preceded by a random gap. With no gap valid just
  // stays high into the next item.
  task automatic send_item(input logic [OP_W-1:0] op, input logic [STEPS_W-1:0] st);
    int gap;
    gap = quiet_in ? 0 : $urandom_range(0, 12);
    if (gap != 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_chan.valid <= 1'b1;
    in_chan.op    <= op;
    in_chan.steps <= st;
    do @(posedge clk); while (!in_chan.ready);
    @(negedge clk);
  endtask

  // Hold off the sender until every predicted result has come out.
  task automatic drain_results();
    in_chan.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // Drain, then let the result register empty before going on.
  task automatic settle();
    drain_results();
    repeat (4) @(negedge clk);
  endtask

  // Config write, then wait out the interval rebuild (ready drops for it).
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.write_reg(idx, data);
    repeat (2) @(posedge clk);
    do @(posedge clk); while (!in_chan.ready);
    @(negedge clk);
  endtask

  // Mostly runs of ticks so that steps get taken, with moves, stops and
  // the unused op mixed in. Tick items carry junk in the steps field.
  task automatic run_random(input int count);
    int pick;
    int mag;
    logic [OP_W-1:0]    op;
    logic [STEPS_W-1:0] st;
    for (int k = 0; k < count; k++) begin
      if ($urandom_range(0, 60) == 0) drain_results();
      pick = $urandom_range(0, 99);
      st   = STEPS_W'($urandom);
      if (pick < 84) begin
        op = OP_TICK;
      end else if (pick < 94) begin
        op = OP_MOVE;
        case ($urandom_range(0, 9))
          6: st = '0;
          7: ;                       // full random count
          8: st = 16'h8000;          // most negative
          9: st = 16'h7FFF;          // most positive
          default: begin
            mag = $urandom_range(1, 12);
            st = $urandom_range(0, 1) ? STEPS_W'(mag) : STEPS_W'(-mag);
          end
        endcase
      end else if (pick < 98) begin
        op = OP_STOP;
      end else begin
        op = OP_UNUSED;
      end
      send_item(op, st);
    end
  endtask

  initial begin : stimulus
    logic [CFG_DATA_W-1:0] rev;
    logic [CFG_DATA_W-1:0] spd;
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = CFG_STEPS_PER_REV;
    cfg_wdata     = '0;
    in_chan.valid = 1'b0;
    in_chan.op    = OP_TICK;
    in_chan.steps = '0;
    quiet_in      = 1'b0;
    quiet_out     = 1'b0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    // Directed part under the reset config (interval 915).
    send_item(OP_TICK, 16'h0000);     // idle tick, nothing to do
    send_item(OP_MOVE, 16'd3);        // forward move
    send_item(OP_TICK, 16'hFFFF);     // elapsed starts saturated: steps at once
    send_item(OP_TICK, 16'h0000);     // too early for the next step
    send_item(OP_UNUSED, 16'hFFFF);   // unused op: state reported unchanged
    send_item(OP_MOVE, 16'd5);        // move while busy replaces the count
    send_item(OP_STOP, 16'h0000);     // stop while busy: coils off, count dropped
    send_item(OP_MOVE, 16'hFFFF);     // -1: backward
    send_item(OP_MOVE, 16'h0000);     // zero move keeps the direction
    send_item(OP_MOVE, 16'h8000);     // -32768 loads 32768
    send_item(OP_MOVE, 16'h7FFF);     // largest forward move
    send_item(OP_MOVE, 16'hFFFE);     // -2
    send_item(OP_STOP, 16'h0000);
    send_item(OP_TICK, 16'h0000);

    // Config phases: fastest interval, zero settings, slowest settings,
    // clamped speeds with junk in the upper data byte, then random ones.
    for (int p = 0; p < 7; p++) begin
      case (p)
        0: begin rev = 16'hFFFF; spd = 16'h00FF; end
        1: begin rev = 16'h0000; spd = 16'hAB00; end
        2: begin rev = 16'h0001; spd = 16'hFE01; end
        3: begin rev = 16'hFFFF; spd = 16'hFF10; end
        default: begin
          rev = CFG_DATA_W'($urandom_range(30000, 65535));
          spd = {8'($urandom), 8'($urandom_range(8, 255))};
        end
      endcase
      settle();
      write_reg(CFG_STEPS_PER_REV, rev);
      write_reg(CFG_SPEED_RPM, spd);
      quiet_in  = ($urandom_range(0, 3) == 0);
      quiet_out = ($urandom_range(0, 3) == 0);
      // Slow intervals never get past the first step; keep them short.
      run_random((sb.interval <= 400) ? 120 : 25);
    end

    settle();
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
